// File: src/pgfi_pkg.sv
// ----------------------------------------------------------------------------
// pgfi_pkg
// Shared types, widths and face-tag helpers for the periodic grid face index.
// ----------------------------------------------------------------------------
package pgfi_pkg;

  localparam int NUM_DIMS   = 3;   // 1..4
  localparam int COORD_BITS = 10;  // 1..10, used bits of each coordinate

  localparam int COORD_W = 10;     // port width of a coordinate
  localparam int SIZE_W  = 11;
  localparam int TAG_W   = 3;      // port width of mask / shift
  localparam int IDX_W   = 32;
  localparam int CELL_W  = 30;
  localparam int REG_W   = 2;
  localparam int CNT_W   = NUM_DIMS + 1;  // holds any face count or rank

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_SIZE_X   = 2'd0;
  localparam logic [REG_W-1:0] REG_SIZE_Y   = 2'd1;
  localparam logic [REG_W-1:0] REG_SIZE_Z   = 2'd2;
  localparam logic [REG_W-1:0] REG_PERIODIC = 2'd3;

  localparam logic FUNC_FACE_INDEX = 1'b0;
  localparam logic FUNC_MIRROR     = 1'b1;

  // one item on its way down the chain of axis cells
  typedef struct packed {
    logic                                 func;
    logic [NUM_DIMS-1:0]                  mask;
    logic [NUM_DIMS-1:0]                  shift;
    logic [NUM_DIMS-1:0]                  step;   // lane 0 is the next cell's axis
    logic [NUM_DIMS-1:0]                  fwd;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord;
    logic [IDX_W-1:0]                     acc;
    logic [IDX_W-1:0]                     dx;     // stride of the next axis
    logic                                 err;
  } pgfi_beat_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [IDX_W-1:0]  global_face_index;
    logic [TAG_W-1:0]  new_mask;
    logic [TAG_W-1:0]  new_shift;
    logic              boundary_error;
  } pgfi_res_t;

  function automatic logic [CNT_W-1:0] popcount(logic [NUM_DIMS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  // number of masks with the same popcount as m
  function automatic logic [CNT_W-1:0] face_count(logic [NUM_DIMS-1:0] m);
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] n;
    k = popcount(m);
    n = '0;
    for (int j = 0; j < (1 << NUM_DIMS); j++) begin
      if (popcount(NUM_DIMS'(j)) == k) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  // number of masks below m with the same popcount
  function automatic logic [CNT_W-1:0] face_rank(logic [NUM_DIMS-1:0] m);
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] r;
    k = popcount(m);
    r = '0;
    for (int j = 0; j < (1 << NUM_DIMS); j++) begin
      if ((NUM_DIMS'(j) < m) && (popcount(NUM_DIMS'(j)) == k)) begin
        r = r + 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: src/pgfi_if.sv
// ----------------------------------------------------------------------------
// pgfi interfaces
// Valid/ready channels for face queries, results and register writes.
// ----------------------------------------------------------------------------
interface pgfi_in_if import pgfi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [TAG_W-1:0]   face_mask;
  logic [TAG_W-1:0]   face_shift;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  modport source (output valid, func, face_mask, face_shift, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, face_mask, face_shift, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pgfi_out_if import pgfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_index;
  logic [IDX_W-1:0]  global_face_index;
  logic [TAG_W-1:0]  new_mask;
  logic [TAG_W-1:0]  new_shift;
  logic              boundary_error;

  modport source (output valid, cell_index, global_face_index, new_mask, new_shift,
                  boundary_error, input ready);
  modport sink   (input valid, cell_index, global_face_index, new_mask, new_shift,
                  boundary_error, output ready);
endinterface

interface pgfi_cfg_if import pgfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [SIZE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/pgfi_cell.sv
// ----------------------------------------------------------------------------
// pgfi_cell
// One axis of the index chain: adds coord * stride, applies the wrapped step
// and hands the next stride and the remaining lanes to its neighbor.
// ----------------------------------------------------------------------------
module pgfi_cell import pgfi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pgfi_beat_t        in_beat_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              periodic_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pgfi_beat_t        out_beat_o
);

  logic                  valid_q;
  pgfi_beat_t            beat_q, beat_d;
  logic [COORD_BITS-1:0] coord;
  logic [IDX_W-1:0]      span, wrap, cterm, acc1;
  logic                  at_top;

  always_comb begin
    coord  = in_beat_i.coord[0];
    span   = IDX_W'(in_beat_i.dx * IDX_W'(size_i));
    wrap   = span - in_beat_i.dx;                // dx * (size - 1) mod 2^32
    cterm  = IDX_W'(in_beat_i.dx * IDX_W'(coord));
    acc1   = in_beat_i.acc + cterm;
    at_top = (IDX_W'(coord) + 1'b1) >= IDX_W'(size_i);

    beat_d       = in_beat_i;
    beat_d.dx    = span;
    beat_d.coord = in_beat_i.coord >> COORD_BITS;
    beat_d.step  = in_beat_i.step >> 1;
    beat_d.fwd   = in_beat_i.fwd >> 1;
    beat_d.acc   = acc1;
    if (in_beat_i.step[0]) begin
      if (!periodic_i) begin
        beat_d.err = 1'b1;
      end else if (in_beat_i.fwd[0]) begin
        beat_d.acc = at_top ? acc1 - wrap : acc1 + in_beat_i.dx;
      end else begin
        beat_d.acc = (coord == '0) ? acc1 + wrap : acc1 - in_beat_i.dx;
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_d;
    end
  end

endmodule

// File: src/pgfi_emit.sv
// ----------------------------------------------------------------------------
// pgfi_emit
// End of the chain: scales the cell index by faces per cell, adds the face
// rank or builds the mirrored tag, and holds the result beat.
// ----------------------------------------------------------------------------
module pgfi_emit import pgfi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pgfi_beat_t in_beat_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pgfi_res_t  out_res_o
);

  logic             valid_q;
  pgfi_res_t        res_q, res_d;
  logic [CNT_W-1:0] nf, rank;

  always_comb begin
    nf    = face_count(in_beat_i.mask);
    rank  = face_rank(in_beat_i.mask);
    res_d = '0;
    if (in_beat_i.err) begin
      res_d.boundary_error = 1'b1;
    end else begin
      res_d.cell_index = in_beat_i.acc[CELL_W-1:0];
      case (in_beat_i.func)
        FUNC_FACE_INDEX: begin
          res_d.global_face_index = IDX_W'(in_beat_i.acc * IDX_W'(nf)) + IDX_W'(rank);
        end
        FUNC_MIRROR: begin
          res_d.new_mask  = TAG_W'(in_beat_i.mask);
          res_d.new_shift = TAG_W'(~in_beat_i.shift & in_beat_i.mask);
        end
        default: begin
          res_d.cell_index = '0;
        end
      endcase
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: src/periodic_grid_face_index.sv
// ----------------------------------------------------------------------------
// periodic_grid_face_index
// Global face index / mirrored face lookup on a periodic 3-D cell grid.
// ----------------------------------------------------------------------------
// Channels: in_i carries face queries (func, face_mask, face_shift, coords),
// out_o carries one result beat per query, cfg_i writes the axis sizes and
// the periodic-axis mask. cfg_i is always ready; write it only while no
// query is in flight.
// The query walks a chain of one cell per axis (stride, wrap step, coord
// term), then an output stage that applies faces per cell and the face rank
// or builds the mirrored tag. One query is accepted every cycle while the
// chain is not full; each stage registers its beat.
// Every stage has its own valid bit and advances when its successor is empty
// or moving, so bubbles collapse: when out_o stalls, queries keep entering
// until the chain is full, then in_i.ready drops.
// Reset empties the chain and sets sizes to 1 and all axes periodic.
// ----------------------------------------------------------------------------
module periodic_grid_face_index import pgfi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pgfi_in_if.sink    in_i,
  pgfi_out_if.source out_o,
  pgfi_cfg_if.sink   cfg_i
);

  logic [2:0][SIZE_W-1:0] size_q;
  logic [TAG_W-1:0]       periodic_q;

  logic [2:0][COORD_BITS-1:0]         coord_all;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] in_coord;
  logic [NUM_DIMS-1:0][SIZE_W-1:0]     axis_size;
  logic [NUM_DIMS-1:0]                 axis_per;
  logic [NUM_DIMS-1:0]                 m, d;

  pgfi_beat_t beat  [NUM_DIMS+1];
  logic       vld   [NUM_DIMS+1];
  logic       rdy   [NUM_DIMS+1];
  pgfi_res_t  res;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= {3{SIZE_W'(1)}};
      periodic_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SIZE_X:   size_q[0]  <= cfg_i.data;
        REG_SIZE_Y:   size_q[1]  <= cfg_i.data;
        REG_SIZE_Z:   size_q[2]  <= cfg_i.data;
        REG_PERIODIC: periodic_q <= cfg_i.data[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign coord_all = {in_i.coord_z[COORD_BITS-1:0], in_i.coord_y[COORD_BITS-1:0],
                      in_i.coord_x[COORD_BITS-1:0]};

  // axes past the third have coord 0, size 1 and never wrap
  for (genvar a = 0; a < NUM_DIMS; a++) begin : g_axis
    if (a < 3) begin : g_real
      assign in_coord[a]  = coord_all[a];
      assign axis_size[a] = size_q[a];
      assign axis_per[a]  = periodic_q[a];
    end else begin : g_pad
      assign in_coord[a]  = '0;
      assign axis_size[a] = SIZE_W'(1);
      assign axis_per[a]  = 1'b0;
    end
  end

  assign m = NUM_DIMS'(in_i.face_mask);
  assign d = NUM_DIMS'(in_i.face_shift);

  always_comb begin
    beat[0].func  = in_i.func;
    beat[0].mask  = m;
    beat[0].shift = d;
    beat[0].step  = (in_i.func == FUNC_MIRROR) ? m : d;
    beat[0].fwd   = (in_i.func == FUNC_MIRROR) ? d : '1;
    beat[0].coord = in_coord;
    beat[0].acc   = '0;
    beat[0].dx    = IDX_W'(1);
    beat[0].err   = 1'b0;
  end

  assign vld[0]     = in_i.valid;
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_cell
    pgfi_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_beat_i   (beat[k]),
      .size_i      (axis_size[k]),
      .periodic_i  (axis_per[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_beat_o  (beat[k+1])
    );
  end

  pgfi_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[NUM_DIMS]),
    .in_ready_o  (rdy[NUM_DIMS]),
    .in_beat_i   (beat[NUM_DIMS]),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.cell_index        = res.cell_index;
  assign out_o.global_face_index = res.global_face_index;
  assign out_o.new_mask          = res.new_mask;
  assign out_o.new_shift         = res.new_shift;
  assign out_o.boundary_error    = res.boundary_error;

endmodule

// File: src/pgfi_chk.sv
// ----------------------------------------------------------------------------
// pgfi_chk
// Port-level checks on the result channel of periodic_grid_face_index.
// ----------------------------------------------------------------------------
module pgfi_chk import pgfi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CELL_W-1:0] cell_index_i,
  input logic [IDX_W-1:0]  global_face_index_i,
  input logic [TAG_W-1:0]  new_mask_i,
  input logic [TAG_W-1:0]  new_shift_i,
  input logic              boundary_error_i
);

  // an error beat carries nothing else
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && boundary_error_i |->
      cell_index_i == '0 && global_face_index_i == '0 &&
      new_mask_i == '0 && new_shift_i == '0)
    else $error("error beat with nonzero fields");

  // face index and mirrored tag are never both present
  a_func_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> global_face_index_i == '0 || (new_mask_i == '0 && new_shift_i == '0))
    else $error("face index and mirrored tag both set");

  // mirrored shift stays inside the mask
  a_shift_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (new_shift_i & ~new_mask_i) == '0)
    else $error("new_shift outside new_mask");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(cell_index_i) && $stable(global_face_index_i) &&
      $stable(new_shift_i) && $stable(boundary_error_i))
    else $error("stalled result beat changed");

endmodule

bind periodic_grid_face_index pgfi_chk u_pgfi_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .cell_index_i        (out_o.cell_index),
  .global_face_index_i (out_o.global_face_index),
  .new_mask_i          (out_o.new_mask),
  .new_shift_i         (out_o.new_shift),
  .boundary_error_i    (out_o.boundary_error)
);

// File: sim/tb_periodic_grid_face_index.sv
// ----------------------------------------------------------------------------
// tb_periodic_grid_face_index
// Self-checking bench for the periodic grid face index lookup. Face queries go
// in over a valid/ready channel with random sender gaps. A local model of the
// face lookup predicts each result. Every result beat is compared field by
// field with the oldest prediction while the receiver stalls at random.
// Directed queries cover face ranks, wrap steps, open axes and size zero.
// Random traffic follows over several grid settings, then a long receiver
// hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_periodic_grid_face_index;
  import pgfi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXES = 3;

  logic clk_i;
  logic rst_ni;

  pgfi_in_if  in_if ();
  pgfi_out_if out_if ();
  pgfi_cfg_if cfg_if ();

  periodic_grid_face_index u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  typedef struct {
    logic               func;
    logic [TAG_W-1:0]   mask;
    logic [TAG_W-1:0]   shift;
    logic [COORD_W-1:0] coord [AXES];
  } face_query_t;

  // register copies, updated when a write beat is taken
  logic [SIZE_W-1:0] grid_size [AXES];
  logic [TAG_W-1:0]  wrap_axes;

  pgfi_res_t   pending_faces [$];
  pgfi_res_t   want_face;
  int unsigned fail_count;
  int unsigned hold_off_cycles;
  bit          tx_gaps;
  bit          rx_gaps;

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // face lookup model
  // --------------------------------------------------------------------------
  function automatic pgfi_res_t predict_face(face_query_t q);
    logic [IDX_W-1:0] acc;
    logic [IDX_W-1:0] stride;
    logic [IDX_W-1:0] span;
    logic [TAG_W-1:0] moved;
    logic [TAG_W-1:0] fwd;
    logic             fault;
    int unsigned      faces;
    int unsigned      rank;
    pgfi_res_t        r;
    moved  = (q.func == FUNC_MIRROR) ? q.mask : q.shift;
    fwd    = (q.func == FUNC_MIRROR) ? q.shift : '1;
    acc    = '0;
    stride = 32'd1;
    fault  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      span = IDX_W'(grid_size[a]) - 32'd1;   // size zero wraps to all ones
      if (moved[a]) begin
        if (!wrap_axes[a]) begin
          fault = 1'b1;
        end else if (fwd[a]) begin
          if (32'(q.coord[a]) + 32'd1 >= 32'(grid_size[a])) acc = acc - stride * span;
          else acc = acc + stride;
        end else begin
          if (q.coord[a] == '0) acc = acc + stride * span;
          else acc = acc - stride;
        end
      end
      acc    = acc + stride * IDX_W'(q.coord[a]);
      stride = stride * IDX_W'(grid_size[a]);
    end
    r = '0;
    if (fault) begin
      r.boundary_error = 1'b1;
      return r;
    end
    r.cell_index = acc[CELL_W-1:0];
    if (q.func == FUNC_FACE_INDEX) begin
      faces = 0;
      rank  = 0;
      for (int j = 0; j < (1 << AXES); j++) begin
        if ($countones(j) == $countones(q.mask)) begin
          faces++;
          if (j < q.mask) rank++;
        end
      end
      r.global_face_index = acc * IDX_W'(faces) + IDX_W'(rank);
    end else begin
      r.new_mask  = q.mask;
      r.new_shift = ~q.shift & q.mask;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) != 0) return SIZE_W'($urandom_range(1, 1024));
    case ($urandom_range(0, 4))
      0:       return SIZE_W'(0);
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(2);
      3:       return SIZE_W'(1024);
      default: return SIZE_W'(2047);
    endcase
  endfunction

  // mostly inside the grid, with the edges favored
  function automatic logic [COORD_W-1:0] pick_coord(logic [SIZE_W-1:0] sz);
    int unsigned r;
    if (sz == 0 || sz > 1024) return COORD_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return COORD_W'(sz - 1);
    return COORD_W'($urandom_range(0, sz - 1));
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic send_face(logic func, logic [TAG_W-1:0] mask, logic [TAG_W-1:0] shift,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    face_query_t q;
    int unsigned gap;
    q.func     = func;
    q.mask     = mask;
    q.shift    = shift;
    q.coord[0] = x;
    q.coord[1] = y;
    q.coord[2] = z;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.face_mask  <= mask;
    in_if.face_shift <= shift;
    in_if.coord_x    <= x;
    in_if.coord_y    <= y;
    in_if.coord_z    <= z;
    do @(posedge clk_i); while (!in_if.ready);
    pending_faces.push_back(predict_face(q));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SIZE_X:   grid_size[0] = value;
      REG_SIZE_Y:   grid_size[1] = value;
      REG_SIZE_Z:   grid_size[2] = value;
      REG_PERIODIC: wrap_axes    = value[TAG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                          logic [SIZE_W-1:0] sz, logic [TAG_W-1:0] per);
    wait_drained();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_PERIODIC, SIZE_W'(per));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset grid is 1x1x1, all periodic; coords past the edge are added into the index unwrapped
  task automatic test_reset_grid();
    send_face(FUNC_FACE_INDEX, 3'b000, 3'b111, 10'd0, 10'd0, 10'd0);
    send_face(FUNC_MIRROR, 3'b111, 3'b000, 10'd1023, 10'd1023, 10'd1023);
    send_face(FUNC_FACE_INDEX, 3'b111, 3'b000, 10'd1023, 10'd0, 10'd1023);
  endtask

  task automatic test_face_ranks();
    set_grid(11'd4, 11'd5, 11'd6, 3'b111);
    for (int m = 0; m < (1 << AXES); m++) begin
      send_face(FUNC_FACE_INDEX, TAG_W'(m), 3'b000, 10'd1, 10'd2, 10'd3);
    end
    send_face(FUNC_FACE_INDEX, 3'b011, 3'b111, 10'd3, 10'd4, 10'd5);  // forward wrap
    send_face(FUNC_FACE_INDEX, 3'b100, 3'b101, 10'd0, 10'd0, 10'd0);
  endtask

  task automatic test_mirror();
    send_face(FUNC_MIRROR, 3'b111, 3'b000, 10'd0, 10'd0, 10'd0);      // backward wrap
    send_face(FUNC_MIRROR, 3'b111, 3'b000, 10'd2, 10'd2, 10'd2);
    send_face(FUNC_MIRROR, 3'b111, 3'b111, 10'd3, 10'd4, 10'd5);
    send_face(FUNC_MIRROR, 3'b010, 3'b101, 10'd1, 10'd1, 10'd1);      // shift outside mask
    send_face(FUNC_MIRROR, 3'b000, 3'b111, 10'd2, 10'd3, 10'd4);
  endtask

  task automatic test_open_axes();
    set_grid(11'd4, 11'd5, 11'd6, 3'b010);
    send_face(FUNC_FACE_INDEX, 3'b000, 3'b001, 10'd1, 10'd1, 10'd1);  // step on open axis
    send_face(FUNC_MIRROR, 3'b100, 3'b100, 10'd1, 10'd1, 10'd1);
    send_face(FUNC_FACE_INDEX, 3'b101, 3'b010, 10'd3, 10'd4, 10'd5);
    send_face(FUNC_MIRROR, 3'b010, 3'b000, 10'd3, 10'd0, 10'd5);
    set_grid(11'd4, 11'd0, 11'd6, 3'b111);
    send_face(FUNC_FACE_INDEX, 3'b010, 3'b010, 10'd2, 10'd0, 10'd1);  // size zero
    send_face(FUNC_MIRROR, 3'b010, 3'b000, 10'd2, 10'd0, 10'd1);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      logic [COORD_W-1:0] c [AXES];
      case (phase)
        0:       set_grid(11'd1024, 11'd1024, 11'd1024, 3'b111);
        1:       set_grid(11'd1, 11'd1, 11'd1, 3'b000);
        2:       set_grid(11'd2, 11'd2, 11'd2, 3'b111);
        default: set_grid(pick_size(), pick_size(), pick_size(), TAG_W'($urandom));
      endcase
      tx_gaps = phase[0];
      rx_gaps = phase[1];
      for (int n = 0; n < 225; n++) begin
        for (int a = 0; a < AXES; a++) begin
          c[a] = ($urandom_range(0, 4) != 0) ? pick_coord(grid_size[a])
                                             : COORD_W'($urandom);
        end
        send_face(1'($urandom), TAG_W'($urandom), TAG_W'($urandom), c[0], c[1], c[2]);
      end
    end
  endtask

  // receiver holds off while the sender keeps pushing; the chain fills up
  task automatic test_backpressure();
    set_grid(11'd7, 11'd3, 11'd9, 3'b111);
    tx_gaps         = 1'b0;
    rx_gaps         = 1'b1;
    hold_off_cycles = 60;
    for (int n = 0; n < 40; n++) begin
      send_face(1'($urandom), TAG_W'($urandom), TAG_W'($urandom),
                pick_coord(grid_size[0]), pick_coord(grid_size[1]),
                pick_coord(grid_size[2]));
    end
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  initial begin : result_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_gaps && $urandom_range(0, 99) < 30) stall_left = pick_gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (pending_faces.size() == 0) begin
        report_mismatch("unexpected result beat", out_if.cell_index, 0);
      end else begin
        want_face = pending_faces.pop_front();
        if (out_if.cell_index !== want_face.cell_index)
          report_mismatch("cell_index", out_if.cell_index, want_face.cell_index);
        if (out_if.global_face_index !== want_face.global_face_index)
          report_mismatch("global_face_index", out_if.global_face_index,
                          want_face.global_face_index);
        if (out_if.new_mask !== want_face.new_mask)
          report_mismatch("new_mask", out_if.new_mask, want_face.new_mask);
        if (out_if.new_shift !== want_face.new_shift)
          report_mismatch("new_shift", out_if.new_shift, want_face.new_shift);
        if (out_if.boundary_error !== want_face.boundary_error)
          report_mismatch("boundary_error", out_if.boundary_error,
                          want_face.boundary_error);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_FACE_INDEX;
    in_if.face_mask   = '0;
    in_if.face_shift  = '0;
    in_if.coord_x     = '0;
    in_if.coord_y     = '0;
    in_if.coord_z     = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_SIZE_X;
    cfg_if.data       = '0;
    grid_size         = '{SIZE_W'(1), SIZE_W'(1), SIZE_W'(1)};
    wrap_axes         = 3'b111;
    fail_count        = 0;
    hold_off_cycles   = 0;
    tx_gaps           = 1'b0;
    rx_gaps           = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_grid();
    test_face_ranks();
    test_mirror();
    test_open_axes();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ERROR: timeout, %0d results still pending", pending_faces.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
